// ===== design/tcsmd_pkg.sv =====
// Shared types, codes and constants for the text command servo and motor driver.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package tcsmd_pkg;

    // Opcodes of an input word.
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK = 2'd1;
    localparam logic [1:0] OP_SAFE = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DEADBAND = 2'd0;
    localparam logic [1:0] CFG_MIN_DUTY = 2'd1;
    localparam logic [1:0] CFG_MAX_DUTY = 2'd2;
    localparam logic [1:0] CFG_DETACH   = 2'd3;

    // Number parser phases.
    localparam logic [1:0] PH_SKIP = 2'd0;
    localparam logic [1:0] PH_NUM  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam int          IDX_W       = 6;
    localparam logic [5:0]  MAX_CMD_LEN = 6'd49;
    localparam int          STEER_DUTY_BITS = 12;
    localparam logic [11:0] STEER_DUTY_MASK =
        12'((32'd1 << STEER_DUTY_BITS) - 32'd1);

    localparam logic [8:0] ACCUM_MAX    = 9'd511;
    localparam logic [8:0] THROTTLE_MAX = 9'd100;
    localparam logic [8:0] STEER_MAX    = 9'd180;
    localparam logic [7:0] STEER_CENTER = 8'd90;

    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_S     = 8'h53;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // Reset values of the configuration registers.
    localparam logic [7:0]  DEADBAND_RESET = 8'd3;
    localparam logic [11:0] MIN_DUTY_RESET = 12'd225;
    localparam logic [11:0] MAX_DUTY_RESET = 12'd390;
    localparam logic [15:0] DETACH_RESET   = 16'd50;
    localparam logic [11:0] STEER_DUTY_RESET =
        12'((32'(MIN_DUTY_RESET) + 32'(MAX_DUTY_RESET)) / 2);

    // floor(t*255/100) = (t * MOTOR_RECIP) >> MOTOR_SHIFT for t in 0..100.
    localparam logic [22:0] MOTOR_RECIP = 23'd5347860;
    localparam int          MOTOR_SHIFT = 21;
    // floor(p/180) = (p * STEER_RECIP) >> STEER_SHIFT for p below 2^20.
    localparam logic [20:0] STEER_RECIP = 21'd1491309;
    localparam int          STEER_SHIFT = 28;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] command_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  motor_level;
        logic [11:0] steer_duty;
        logic        servo_active;
        logic [6:0]  throttle_now;
        logic [7:0]  steering_now;
        logic        applied;
    } t_out_word;

    typedef struct packed {
        logic [7:0]  steer_deadband;
        logic [11:0] steer_min_duty;
        logic [11:0] steer_max_duty;
        logic [15:0] detach_ticks;
    } t_cfg;

    typedef struct packed {
        logic       key_found;
        logic [1:0] phase;
        logic       negative;
        logic [8:0] accum;
    } t_parse;

    // Word passed from the state stage to the duty scaling stage.
    typedef struct packed {
        logic [7:0]  motor_level;
        logic        servo_active;
        logic [6:0]  throttle_now;
        logic [7:0]  steering_now;
        logic        applied;
        logic        steer_update;
        logic [19:0] steer_product;
    } t_mid;

endpackage

// ===== design/tcsmd_num_parser.sv =====
// One key-and-number parser: next state after one text byte.
// Depends on tcsmd_pkg for the parser state type, phases and characters.
`timescale 1ns / 1ps

module tcsmd_num_parser (
    input  tcsmd_pkg::t_parse i_state,
    input  logic [7:0]        i_byte,
    input  logic [7:0]        i_prev,
    input  logic [7:0]        i_key,
    output tcsmd_pkg::t_parse o_state
);

    logic        w_digit;
    logic        w_space;
    logic        w_sign;
    logic [12:0] w_next;
    logic [8:0]  w_sat;

    assign w_digit = (i_byte >= tcsmd_pkg::CHAR_ZERO) && (i_byte <= tcsmd_pkg::CHAR_NINE);
    assign w_space = (i_byte == tcsmd_pkg::CHAR_SPACE) ||
                     ((i_byte >= tcsmd_pkg::CHAR_TAB) && (i_byte <= tcsmd_pkg::CHAR_CR));
    assign w_sign  = (i_byte == tcsmd_pkg::CHAR_PLUS) || (i_byte == tcsmd_pkg::CHAR_MINUS);

    // accum * 10 + digit, saturating at the accumulator maximum.
    assign w_next = {1'b0, i_state.accum, 3'b000} + {3'b000, i_state.accum, 1'b0}
                  + {9'd0, 4'(i_byte - tcsmd_pkg::CHAR_ZERO)};
    assign w_sat  = (w_next > {4'd0, tcsmd_pkg::ACCUM_MAX}) ? tcsmd_pkg::ACCUM_MAX
                                                           : w_next[8:0];

    always_comb begin
        o_state = i_state;
        if (!i_state.key_found) begin
            if ((i_prev == i_key) && (i_byte == tcsmd_pkg::CHAR_COLON)) begin
                o_state           = '0;
                o_state.key_found = 1'b1;
            end
        end else begin
            unique case (i_state.phase)
                tcsmd_pkg::PH_SKIP: begin
                    if (w_space) begin
                        o_state.phase = tcsmd_pkg::PH_SKIP;
                    end else if (w_sign) begin
                        o_state.negative = (i_byte == tcsmd_pkg::CHAR_MINUS);
                        o_state.phase    = tcsmd_pkg::PH_NUM;
                    end else if (w_digit) begin
                        o_state.accum = w_sat;
                        o_state.phase = tcsmd_pkg::PH_NUM;
                    end else begin
                        o_state.phase = tcsmd_pkg::PH_DONE;
                    end
                end
                tcsmd_pkg::PH_NUM: begin
                    if (w_digit) begin
                        o_state.accum = w_sat;
                    end else begin
                        o_state.phase = tcsmd_pkg::PH_DONE;
                    end
                end
                default: begin
                    o_state.phase = i_state.phase;
                end
            endcase
        end
    end

endmodule

// ===== design/tcsmd_ctrl.sv =====
// State stage: message parsing, throttle and steering state, detach countdown.
// Depends on tcsmd_pkg and tcsmd_num_parser; feeds the duty scaling stage.
`timescale 1ns / 1ps

module tcsmd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  tcsmd_pkg::t_in_word i_word,
    input  tcsmd_pkg::t_cfg     i_cfg,
    input  logic                i_next_ready,
    output logic                o_ready,
    output logic                o_valid,
    output tcsmd_pkg::t_mid     o_mid
);

    logic                   r_valid;
    tcsmd_pkg::t_mid        r_mid;
    logic [6:0]             r_throttle;
    logic [7:0]             r_steering;
    logic [7:0]             r_last_steer;
    logic [7:0]             r_motor;
    logic                   r_servo_on;
    logic [15:0]            r_detach;
    logic [tcsmd_pkg::IDX_W-1:0] r_byte_idx;
    logic                   r_ended;
    logic [7:0]             r_prev;
    tcsmd_pkg::t_parse      r_tp;
    tcsmd_pkg::t_parse      r_sp;

    logic [6:0]             n_throttle;
    logic [7:0]             n_steering;
    logic [7:0]             n_last_steer;
    logic [7:0]             n_motor;
    logic                   n_servo_on;
    logic [15:0]            n_detach;
    logic [tcsmd_pkg::IDX_W-1:0] n_byte_idx;
    logic                   n_ended;
    logic [7:0]             n_prev;
    tcsmd_pkg::t_parse      n_tp;
    tcsmd_pkg::t_parse      n_sp;
    tcsmd_pkg::t_mid        n_mid;

    tcsmd_pkg::t_parse      w_tp_fed;
    tcsmd_pkg::t_parse      w_sp_fed;
    tcsmd_pkg::t_parse      w_tp_msg;
    tcsmd_pkg::t_parse      w_sp_msg;
    logic                   w_move;
    logic                   w_apply;
    logic                   w_clear;
    logic                   w_update;
    logic [29:0]            w_motor_prod;
    logic [7:0]             w_diff;
    logic [11:0]            w_span;
    logic [19:0]            w_steer_prod;

    function automatic logic [8:0] f_clamp(tcsmd_pkg::t_parse p, logic [8:0] hi);
        logic [8:0] v;
        v = (p.accum > hi) ? hi : p.accum;
        if (p.negative || (p.accum == 9'd0)) begin
            v = 9'd0;
        end
        return v;
    endfunction

    tcsmd_num_parser u_t_parser (
        .i_state (r_tp),
        .i_byte  (i_word.command_byte),
        .i_prev  (r_prev),
        .i_key   (tcsmd_pkg::CHAR_T),
        .o_state (w_tp_fed)
    );

    tcsmd_num_parser u_s_parser (
        .i_state (r_sp),
        .i_byte  (i_word.command_byte),
        .i_prev  (r_prev),
        .i_key   (tcsmd_pkg::CHAR_S),
        .o_state (w_sp_fed)
    );

    assign o_ready = !r_valid || i_next_ready;
    assign w_move  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_mid   = r_mid;

    always_comb begin
        n_throttle   = r_throttle;
        n_steering   = r_steering;
        n_byte_idx   = r_byte_idx;
        n_ended      = r_ended;
        n_prev       = r_prev;
        n_tp         = r_tp;
        n_sp         = r_sp;
        n_detach     = r_detach;
        n_servo_on   = r_servo_on;
        w_apply      = 1'b0;
        w_clear      = 1'b0;
        w_tp_msg     = r_tp;
        w_sp_msg     = r_sp;

        unique case (i_word.opcode)
            tcsmd_pkg::OP_BYTE: begin
                if (!r_ended && (r_byte_idx < tcsmd_pkg::MAX_CMD_LEN)) begin
                    if (i_word.command_byte == 8'd0) begin
                        n_ended = 1'b1;
                    end else begin
                        w_tp_msg   = w_tp_fed;
                        w_sp_msg   = w_sp_fed;
                        n_tp       = w_tp_fed;
                        n_sp       = w_sp_fed;
                        n_prev     = i_word.command_byte;
                        n_byte_idx = r_byte_idx + 1'b1;
                    end
                end
                if (i_word.last_byte) begin
                    if (w_tp_msg.key_found) begin
                        n_throttle = 7'(f_clamp(w_tp_msg, tcsmd_pkg::THROTTLE_MAX));
                    end
                    if (w_sp_msg.key_found) begin
                        n_steering = 8'(f_clamp(w_sp_msg, tcsmd_pkg::STEER_MAX));
                    end
                    w_apply = 1'b1;
                    w_clear = 1'b1;
                end
            end
            tcsmd_pkg::OP_TICK: begin
                if (r_detach != 16'd0) begin
                    n_detach = r_detach - 16'd1;
                    if (r_detach == 16'd1) begin
                        n_servo_on = 1'b0;
                    end
                end
            end
            tcsmd_pkg::OP_SAFE: begin
                n_throttle = 7'd0;
                n_steering = tcsmd_pkg::STEER_CENTER;
                w_apply    = 1'b1;
                w_clear    = 1'b1;
            end
            default: begin
                w_apply = 1'b0;
            end
        endcase

        if (w_clear) begin
            n_byte_idx = '0;
            n_ended    = 1'b0;
            n_prev     = 8'd0;
            n_tp       = '0;
            n_sp       = '0;
        end
    end

    // Motor duty and steering scale product come from the post-command values.
    assign w_motor_prod = 30'(n_throttle) * 30'(tcsmd_pkg::MOTOR_RECIP);
    assign w_diff       = (n_steering > r_last_steer) ? (n_steering - r_last_steer)
                                                      : (r_last_steer - n_steering);
    assign w_span       = (i_cfg.steer_max_duty >= i_cfg.steer_min_duty)
                        ? (i_cfg.steer_max_duty - i_cfg.steer_min_duty) : 12'd0;
    assign w_steer_prod = 20'(n_steering) * 20'(w_span);
    assign w_update     = w_apply && (w_diff > i_cfg.steer_deadband);

    always_comb begin
        n_motor      = w_apply ? w_motor_prod[tcsmd_pkg::MOTOR_SHIFT +: 8] : r_motor;
        n_last_steer = w_update ? n_steering : r_last_steer;
    end

    always_comb begin
        n_mid               = r_mid;
        n_mid.motor_level   = n_motor;
        n_mid.servo_active  = w_update ? 1'b1 : n_servo_on;
        n_mid.throttle_now  = n_throttle;
        n_mid.steering_now  = n_steering;
        n_mid.applied       = w_apply;
        n_mid.steer_update  = w_update;
        n_mid.steer_product = w_steer_prod;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_throttle   <= 7'd0;
            r_steering   <= tcsmd_pkg::STEER_CENTER;
            r_last_steer <= tcsmd_pkg::STEER_CENTER;
            r_motor      <= 8'd0;
            r_servo_on   <= 1'b1;
            r_detach     <= 16'd0;
            r_byte_idx   <= '0;
            r_ended      <= 1'b0;
            r_prev       <= 8'd0;
            r_tp         <= '0;
            r_sp         <= '0;
        end else begin
            if (w_move) begin
                r_valid      <= 1'b1;
                r_throttle   <= n_throttle;
                r_steering   <= n_steering;
                r_last_steer <= n_last_steer;
                r_motor      <= n_motor;
                r_servo_on   <= n_mid.servo_active;
                r_detach     <= w_update ? ((i_cfg.detach_ticks == 16'd0) ? 16'd1
                                                                          : i_cfg.detach_ticks)
                                         : n_detach;
                r_byte_idx   <= n_byte_idx;
                r_ended      <= n_ended;
                r_prev       <= n_prev;
                r_tp         <= n_tp;
                r_sp         <= n_sp;
            end else if (i_next_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_mid <= n_mid;
        end
    end

    // A running countdown means the servo has been attached and not yet stopped.
    a_count_servo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_detach != 16'd0) |-> r_servo_on)
        else $error("detach countdown running while servo is off");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_throttle <= 7'd100) && (r_steering <= 8'd180) && (r_last_steer <= 8'd180))
        else $error("throttle or steering state out of range");

    a_byte_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_idx <= tcsmd_pkg::MAX_CMD_LEN)
        else $error("message byte index past the parsed length");

endmodule

// ===== design/tcsmd_scale.sv =====
// Duty scaling stage: divides the steering product by 180, holds the servo
// duty and the result register. Depends on tcsmd_pkg.
`timescale 1ns / 1ps

module tcsmd_scale (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  tcsmd_pkg::t_mid      i_mid,
    input  tcsmd_pkg::t_cfg      i_cfg,
    input  logic                 i_stall,
    output logic                 o_ready,
    output logic                 o_valid,
    output tcsmd_pkg::t_out_word o_word
);

    logic                 r_valid;
    tcsmd_pkg::t_out_word r_word;
    logic [11:0]          r_steer_duty;
    logic [11:0]          n_steer_duty;
    logic                 w_move;
    logic [40:0]          w_quot_prod;
    logic [12:0]          w_duty_sum;

    assign o_ready = !r_valid || !i_stall;
    assign w_move  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // Division by 180 through a reciprocal multiply; exact for 20-bit products.
    assign w_quot_prod  = 41'(i_mid.steer_product) * 41'(tcsmd_pkg::STEER_RECIP);
    assign w_duty_sum   = {1'b0, i_cfg.steer_min_duty}
                        + {1'b0, w_quot_prod[tcsmd_pkg::STEER_SHIFT +: 12]};
    assign n_steer_duty = i_mid.steer_update
                        ? (w_duty_sum[11:0] & tcsmd_pkg::STEER_DUTY_MASK) : r_steer_duty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_steer_duty <= tcsmd_pkg::STEER_DUTY_RESET;
        end else begin
            if (w_move) begin
                r_valid      <= 1'b1;
                r_steer_duty <= n_steer_duty;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_word.motor_level  <= i_mid.motor_level;
            r_word.steer_duty   <= n_steer_duty;
            r_word.servo_active <= i_mid.servo_active;
            r_word.throttle_now <= i_mid.throttle_now;
            r_word.steering_now <= i_mid.steering_now;
            r_word.applied      <= i_mid.applied;
        end
    end

    // The servo duty only moves when a word carries a steering update.
    a_duty_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && !i_mid.steer_update) |=> $stable(r_steer_duty))
        else $error("servo duty changed without a steering update");

    a_update_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> (r_word.steer_duty == r_steer_duty))
        else $error("result word does not show the current servo duty");

endmodule

// ===== design/text_command_servo_motor_driver_unit.sv =====
// Top level of the text command servo and motor driver: configuration
// registers, input register and the two processing stages.
// Depends on tcsmd_pkg, tcsmd_ctrl, tcsmd_scale.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                   Payload
//  in        to block   i_in_valid / o_in_stall     i_in_word  (tcsmd_pkg::t_in_word)
//  out       from block o_out_valid / i_out_stall   o_out_word (tcsmd_pkg::t_out_word)
//  cfg       to block   i_cfg_we                    i_cfg_index, i_cfg_data
//
//  One word is accepted per cycle while o_in_stall is low; every word gives one result word.
//  A result passes from the input register through the state stage
//  (parsers, clamps, countdown, motor duty), then the scaling stage
//  (steering product divided by 180) into the result register.
//  Reset is synchronous to i_clk and active low; it loads the power-on state.
//  A stall on the output backs up through the stages in the same cycle, as far as the first empty register.

module text_command_servo_motor_driver_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  tcsmd_pkg::t_in_word   i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output tcsmd_pkg::t_out_word  o_out_word,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    tcsmd_pkg::t_cfg     r_cfg;
    logic                r_in_valid;
    tcsmd_pkg::t_in_word r_in_word;
    logic                w_accept;
    logic                w_ctrl_ready;
    logic                w_mid_valid;
    tcsmd_pkg::t_mid     w_mid;
    logic                w_scale_ready;

    assign o_in_stall = r_in_valid && !w_ctrl_ready;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steer_deadband <= tcsmd_pkg::DEADBAND_RESET;
            r_cfg.steer_min_duty <= tcsmd_pkg::MIN_DUTY_RESET;
            r_cfg.steer_max_duty <= tcsmd_pkg::MAX_DUTY_RESET;
            r_cfg.detach_ticks   <= tcsmd_pkg::DETACH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcsmd_pkg::CFG_DEADBAND: r_cfg.steer_deadband <= i_cfg_data[7:0];
                tcsmd_pkg::CFG_MIN_DUTY: r_cfg.steer_min_duty <= i_cfg_data[11:0];
                tcsmd_pkg::CFG_MAX_DUTY: r_cfg.steer_max_duty <= i_cfg_data[11:0];
                tcsmd_pkg::CFG_DETACH:   r_cfg.detach_ticks   <= i_cfg_data;
                default:                 r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_ctrl_ready) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_word <= i_in_word;
        end
    end

    tcsmd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .i_word       (r_in_word),
        .i_cfg        (r_cfg),
        .i_next_ready (w_scale_ready),
        .o_ready      (w_ctrl_ready),
        .o_valid      (w_mid_valid),
        .o_mid        (w_mid)
    );

    tcsmd_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_mid_valid),
        .i_mid   (w_mid),
        .i_cfg   (r_cfg),
        .i_stall (i_out_stall),
        .o_ready (w_scale_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word)
    );

    // A held input word must be moved on as soon as the state stage frees up.
    a_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_ctrl_ready && !w_accept) |=> !r_in_valid)
        else $error("input register kept a word the state stage took");

endmodule
